@@ rtl/dpxc_pkg.sv @@
// Shared types and constants for the dual-polarization cross-correlator.
// Holds the request and response item structs and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps

package dpxc_pkg;

    // Fixed field widths of the request and response items.
    localparam int OP_W      = 2;
    localparam int STATION_W = 3;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 48;

    // Default build parameters.
    localparam int STATIONS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ACC_BITS_DEF    = 48;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]             operation;
        logic [STATION_W-1:0]        station;
        logic [STATION_W-1:0]        other_station;
        logic signed [IN_W-1:0]      x_real;
        logic signed [IN_W-1:0]      x_imag;
        logic signed [IN_W-1:0]      y_real;
        logic signed [IN_W-1:0]      y_imag;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] xx_real;
        logic signed [OUT_W-1:0] xx_imag;
        logic signed [OUT_W-1:0] xy_real;
        logic signed [OUT_W-1:0] xy_imag;
        logic signed [OUT_W-1:0] yx_real;
        logic signed [OUT_W-1:0] yx_imag;
        logic signed [OUT_W-1:0] yy_real;
        logic signed [OUT_W-1:0] yy_imag;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture the request item
        logic sample_wr;    // store the sample and start the pair loop
        logic issue;        // issue one pair of the loop
        logic rd_issue;     // issue the accumulator read of a read item
        logic out_load;     // load the response register
        logic clr;          // write one row of the clearing pass
        logic clr_samples;  // the clearing pass also zeroes the sample store
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic station_ok;   // captured add item names an existing station
        logic loop_last;    // the pair being issued is the last one
        logic pipe_busy;    // multiply/accumulate pipeline still holds pairs
        logic out_free;     // response register can take a new item
        logic clr_last;     // clearing pass is at its last row
    } status_t;

endpackage

@@ rtl/dpxc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dpxc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/dpxc_ctrl.sv @@
// Controller state machine of the cross-correlator.
// Sequences clearing passes, the per-sample pair loop and pair reads. Uses dpxc_pkg.
`timescale 1ns / 1ps

module dpxc_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic [dpxc_pkg::OP_W-1:0]   req_operation,
    output logic                        req_ready,
    input  dpxc_pkg::status_t           status,
    output dpxc_pkg::cmd_t              cmd
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_ADD_WR,
        S_ADD_LOOP,
        S_DRAIN,
        S_RD_ISSUE,
        S_RD_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   clr_samples_reg, clr_samples_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Reset starts with a pass that zeroes both stores.
            state_reg       <= S_CLR;
            clr_samples_reg <= 1'b1;
        end
        else
        begin
            state_reg       <= state_next;
            clr_samples_reg <= clr_samples_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_samples_next = clr_samples_reg;
        cmd              = '0;
        req_ready        = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr         = 1'b1;
                cmd.clr_samples = clr_samples_reg;
                if (status.clr_last)
                begin
                    clr_samples_next = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    case (req_operation)
                        dpxc_pkg::OP_ADD:   state_next = S_ADD_WR;
                        dpxc_pkg::OP_READ:  state_next = S_RD_ISSUE;
                        dpxc_pkg::OP_CLEAR: state_next = S_CLR;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_WR:
            begin
                if (status.station_ok)
                begin
                    cmd.sample_wr = 1'b1;
                    state_next    = S_ADD_LOOP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ADD_LOOP:
            begin
                cmd.issue = 1'b1;
                if (status.loop_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/dpxc_datapath.sv @@
// Datapath of the cross-correlator: sample store, accumulator store, the four
// complex multiply-accumulate lanes with saturation, and the response register.
// Uses dpxc_pkg and dpxc_ram.
`timescale 1ns / 1ps

module dpxc_datapath #(
    parameter int STATIONS    = dpxc_pkg::STATIONS_DEF,
    parameter int SAMPLE_BITS = dpxc_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_BITS    = dpxc_pkg::ACC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dpxc_pkg::in_item_t    req,
    input  dpxc_pkg::cmd_t        cmd,
    output dpxc_pkg::status_t     status,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output dpxc_pkg::out_item_t   rsp
);

    localparam int STA_W     = $clog2(STATIONS);
    localparam int PAIRS     = STATIONS * (STATIONS + 1) / 2;
    localparam int PAIR_W    = $clog2(PAIRS);
    localparam int MUL_W     = 2 * STA_W + 1;
    localparam int IN_W      = dpxc_pkg::IN_W;
    localparam int OUT_W     = dpxc_pkg::OUT_W;
    localparam int EXT_W     = (SAMPLE_BITS > IN_W) ? SAMPLE_BITS : IN_W;
    localparam int SROW_W    = 4 * SAMPLE_BITS;
    localparam int PROD_W    = 2 * SAMPLE_BITS + 1;
    localparam int SUM_W     = ((ACC_BITS > PROD_W) ? ACC_BITS : PROD_W) + 1;
    localparam int ROW_W     = 8 * ACC_BITS;
    localparam int OUT_EXT_W = (ACC_BITS > OUT_W) ? ACC_BITS : OUT_W;

    // Low SAMPLE_BITS of a field, read as two's complement.
    function automatic logic signed [SAMPLE_BITS-1:0] to_sample(input logic [IN_W-1:0] f);
        logic [EXT_W-1:0] e;
        e = EXT_W'(f);
        return e[SAMPLE_BITS-1:0];
    endfunction

    // Row of the first pair (s, 0) of station s.
    function automatic logic [PAIR_W-1:0] tri_base(input logic [STA_W-1:0] s);
        logic [MUL_W-1:0] sx;
        logic [MUL_W-1:0] p;
        sx = MUL_W'(s);
        p  = sx * (sx + MUL_W'(1));
        return PAIR_W'(p >> 1);
    endfunction

    function automatic logic [ACC_BITS-1:0] sat(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-ACC_BITS:0] top;
        top = s[SUM_W-1:ACC_BITS-1];
        if ((&top) || !(|top))
        begin
            return s[ACC_BITS-1:0];
        end
        else if (s[SUM_W-1])
        begin
            return {1'b1, {(ACC_BITS - 1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(ACC_BITS - 1){1'b1}}};
        end
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic signed [ACC_BITS-1:0] v);
        logic signed [OUT_EXT_W-1:0] e;
        e = OUT_EXT_W'(v);
        return e[OUT_W-1:0];
    endfunction

    dpxc_pkg::in_item_t  req_reg;
    dpxc_pkg::out_item_t rsp_reg;
    logic                rsp_valid_reg;

    logic [STA_W-1:0]    cnt_reg;
    logic [PAIR_W-1:0]   addr_reg;
    logic [PAIR_W-1:0]   addr1_reg;
    logic [PAIR_W-1:0]   addr2_reg;
    logic [PAIR_W-1:0]   clr_cnt_reg;
    logic                v1_reg;
    logic                v2_reg;
    logic                rd_ok_reg;

    logic signed [SAMPLE_BITS-1:0] a_re [2];
    logic signed [SAMPLE_BITS-1:0] a_im [2];
    logic signed [SAMPLE_BITS-1:0] b_re [2];
    logic signed [SAMPLE_BITS-1:0] b_im [2];
    logic signed [PROD_W-1:0]      prod_next [8];
    logic signed [PROD_W-1:0]      prod_reg  [8];
    logic signed [SUM_W-1:0]       lane_sum  [8];

    logic [STA_W-1:0]              a_idx;
    logic [dpxc_pkg::STATION_W-1:0] rd_hi;
    logic [dpxc_pkg::STATION_W-1:0] rd_lo;
    logic                          rd_ok;
    logic [PAIR_W-1:0]             rd_addr;

    logic                          smp_we;
    logic [STA_W-1:0]              smp_waddr;
    logic [SROW_W-1:0]             smp_wdata;
    logic [SROW_W-1:0]             smp_wrow;
    logic [SROW_W-1:0]             smp_rdata;

    logic                          acc_we;
    logic [PAIR_W-1:0]             acc_waddr;
    logic [ROW_W-1:0]              acc_wdata;
    logic                          acc_re;
    logic [PAIR_W-1:0]             acc_raddr;
    logic [ROW_W-1:0]              acc_rdata;
    logic [ROW_W-1:0]              new_row;
    logic [8*OUT_W-1:0]            rsp_flat;

    // Request decode.
    assign a_idx = STA_W'(req_reg.station);
    assign rd_hi = (req_reg.other_station > req_reg.station) ? req_reg.other_station
                                                             : req_reg.station;
    assign rd_lo = (req_reg.other_station > req_reg.station) ? req_reg.station
                                                             : req_reg.other_station;
    assign rd_ok   = 32'(rd_hi) < STATIONS;
    assign rd_addr = tri_base(STA_W'(rd_hi)) + PAIR_W'(STA_W'(rd_lo));

    // Sample of the new station, lane 0 is X and lane 1 is Y.
    assign a_re[0] = to_sample(req_reg.x_real);
    assign a_im[0] = to_sample(req_reg.x_imag);
    assign a_re[1] = to_sample(req_reg.y_real);
    assign a_im[1] = to_sample(req_reg.y_imag);
    assign smp_wrow = {a_re[0], a_im[0], a_re[1], a_im[1]};

    // Stored sample of the partner station.
    assign b_re[0] = smp_rdata[3*SAMPLE_BITS +: SAMPLE_BITS];
    assign b_im[0] = smp_rdata[2*SAMPLE_BITS +: SAMPLE_BITS];
    assign b_re[1] = smp_rdata[SAMPLE_BITS +: SAMPLE_BITS];
    assign b_im[1] = smp_rdata[0 +: SAMPLE_BITS];

    // Four a*conj(b) products: XX, XY, YX, YY.
    for (genvar k = 0; k < 4; k++)
    begin : g_cmac
        localparam int PA = k / 2;
        localparam int PB = k % 2;
        logic signed [2*SAMPLE_BITS-1:0] m_rr;
        logic signed [2*SAMPLE_BITS-1:0] m_ii;
        logic signed [2*SAMPLE_BITS-1:0] m_ir;
        logic signed [2*SAMPLE_BITS-1:0] m_ri;
        assign m_rr = a_re[PA] * b_re[PB];
        assign m_ii = a_im[PA] * b_im[PB];
        assign m_ir = a_im[PA] * b_re[PB];
        assign m_ri = a_re[PA] * b_im[PB];
        assign prod_next[2*k]   = PROD_W'(m_rr) + PROD_W'(m_ii);
        assign prod_next[2*k+1] = PROD_W'(m_ir) - PROD_W'(m_ri);
    end

    // Saturating accumulate of one pair row.
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            lane_sum[j] = SUM_W'($signed(acc_rdata[j*ACC_BITS +: ACC_BITS]))
                        + SUM_W'(prod_reg[j]);
            new_row[j*ACC_BITS +: ACC_BITS] = sat(lane_sum[j]);
        end
    end

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            rsp_flat[(7-j)*OUT_W +: OUT_W] =
                rd_ok_reg ? to_out($signed(acc_rdata[j*ACC_BITS +: ACC_BITS])) : '0;
        end
    end

    // Memory port selection.
    assign smp_we    = cmd.sample_wr
                     | (cmd.clr & cmd.clr_samples & (clr_cnt_reg < PAIR_W'(STATIONS)));
    assign smp_waddr = cmd.sample_wr ? a_idx : STA_W'(clr_cnt_reg);
    assign smp_wdata = cmd.sample_wr ? smp_wrow : '0;

    assign acc_we    = cmd.clr | v2_reg;
    assign acc_waddr = cmd.clr ? clr_cnt_reg : addr2_reg;
    assign acc_wdata = cmd.clr ? '0 : new_row;
    // The accumulator row is read in the cycle after the sample so both meet the products.
    assign acc_re    = v1_reg | cmd.rd_issue;
    assign acc_raddr = cmd.rd_issue ? rd_addr : addr1_reg;

    dpxc_ram #(
        .WIDTH (SROW_W),
        .DEPTH (STATIONS)
    ) u_smp_ram (
        .clk   (clk),
        .we    (smp_we),
        .waddr (smp_waddr),
        .wdata (smp_wdata),
        .re    (cmd.issue),
        .raddr (cnt_reg),
        .rdata (smp_rdata)
    );

    dpxc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (PAIRS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cmd.clr)
            begin
                clr_cnt_reg <= status.clr_last ? '0 : clr_cnt_reg + PAIR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.sample_wr)
        begin
            cnt_reg  <= '0;
            addr_reg <= tri_base(a_idx);
        end
        else if (cmd.issue)
        begin
            cnt_reg  <= cnt_reg + STA_W'(1);
            addr_reg <= addr_reg + PAIR_W'(1);
        end
        addr1_reg <= addr_reg;
        addr2_reg <= addr1_reg;
        if (v1_reg)
        begin
            for (int j = 0; j < 8; j++)
            begin
                prod_reg[j] <= prod_next[j];
            end
        end
        if (cmd.rd_issue)
        begin
            rd_ok_reg <= rd_ok;
        end
        if (cmd.out_load)
        begin
            rsp_reg <= dpxc_pkg::out_item_t'(rsp_flat);
        end
    end

    assign status.station_ok = 32'(req_reg.station) < STATIONS;
    assign status.loop_last  = (cnt_reg == a_idx);
    assign status.pipe_busy  = v1_reg | v2_reg;
    assign status.out_free   = !rsp_valid_reg || rsp_ready;
    assign status.clr_last   = (clr_cnt_reg == PAIR_W'(PAIRS - 1));

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/dual_pol_cross_correlator.sv @@
// Top level of the dual-polarization cross-correlator.
// Joins the controller and the datapath. Uses dpxc_pkg, dpxc_ctrl and dpxc_datapath.
`timescale 1ns / 1ps

// Correlates dual-polarization complex samples between all station pairs and keeps
// eight saturating accumulators (XX, XY, YX, YY, real and imaginary) per pair.
// One item is worked on at a time. For an add item the pair loop issues one partner
// station per cycle into four complex multiply-accumulate lanes (16 multipliers),
// followed by a two-stage multiply and accumulate pipeline drain; the accumulator
// store's single write port sets the one-pair-per-cycle pace. A read item issues the
// accumulator read, then loads the response register once that register is free.
// A clear item and the pass after reset each sweep the accumulator store's
// STATIONS*(STATIONS+1)/2 rows (36 by default) one row per cycle, during which no
// item is accepted; the pass after reset also zeroes the sample store.
module dual_pol_cross_correlator #(
    parameter int STATIONS    = dpxc_pkg::STATIONS_DEF,
    parameter int SAMPLE_BITS = dpxc_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_BITS    = dpxc_pkg::ACC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  dpxc_pkg::in_item_t   req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output dpxc_pkg::out_item_t  rsp
);

    dpxc_pkg::cmd_t    cmd;
    dpxc_pkg::status_t status;

    dpxc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_operation (req.operation),
        .req_ready     (req_ready),
        .status        (status),
        .cmd           (cmd)
    );

    dpxc_datapath #(
        .STATIONS    (STATIONS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
